FILE: hdl/ipaf_pkg.sv
// Shared types and constants for the IPv4 address pair allowlist filter.
`default_nettype none

package ipaf_pkg;

  // Allowlist table size and the index width that follows from it.
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Request queue between the byte front end and the table back end.
  // The depth must be a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Protocol values.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  // Byte positions within the frame.
  localparam logic [5:0] POS_TYPE_HI   = 6'd12;
  localparam logic [5:0] POS_TYPE_LO   = 6'd13;
  localparam logic [5:0] POS_SRC_FIRST = 6'd26;
  localparam logic [5:0] POS_SRC_LAST  = 6'd29;
  localparam logic [5:0] POS_DST_FIRST = 6'd30;
  localparam logic [5:0] POS_DST_LAST  = 6'd33;
  localparam logic [5:0] ETH_HEADER_LEN = 6'd14;
  localparam logic [5:0] IPV4_MIN_FRAME = 6'd34;

  // Input operation codes.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Reason codes on the result.
  localparam logic [1:0] REASON_NOT_IPV4    = 2'd0;
  localparam logic [1:0] REASON_ALLOWED     = 2'd1;
  localparam logic [1:0] REASON_NOT_IN_TABLE = 2'd2;
  localparam logic [1:0] REASON_TOO_SHORT   = 2'd3;

  // Verdict codes.
  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  // Statistic counter indexes.
  localparam int CNT_FRAMES   = 0;
  localparam int CNT_PASSED   = 1;
  localparam int CNT_NO_MATCH = 2;
  localparam int CNT_SHORT    = 3;
  localparam int STAT_COUNT   = 4;

  // One queued request: either a table write or a finished frame.
  // For a frame, reason holds the early classification; NOT_IN_TABLE
  // marks a frame that still needs the table lookup.
  typedef struct packed {
    logic        is_write;
    logic [5:0]  slot;
    logic        entry_valid;
    logic [1:0]  reason;
    logic [63:0] pair;
  } req_t;

endpackage

`default_nettype wire

FILE: hdl/ipaf_front.sv
// Front end: captures header fields from the byte stream and queues requests.
`default_nettype none

module ipaf_front
  import ipaf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic        op,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        last_byte,
  input  wire logic [5:0]  entry_slot,
  input  wire logic [31:0] entry_source,
  input  wire logic [31:0] entry_dest,
  input  wire logic        entry_valid,
  input  wire logic        queue_full,
  output logic             push,
  output req_t             push_req
);

  logic [5:0]  byte_position;
  logic [15:0] ether_type;
  logic [31:0] source_address;
  logic [31:0] dest_address;

  logic [5:0]  byte_position_next;
  logic [15:0] ether_type_next;
  logic [31:0] source_address_next;
  logic [31:0] dest_address_next;
  logic        accept;
  logic        frame_end;

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;
  assign frame_end  = accept && (op == OP_BYTE) && last_byte;
  assign push       = accept && ((op == OP_WRITE) || last_byte);

  // Header capture for the current byte.
  always_comb begin
    ether_type_next     = ether_type;
    source_address_next = source_address;
    dest_address_next   = dest_address;
    if (byte_position == POS_TYPE_HI || byte_position == POS_TYPE_LO) begin
      ether_type_next = {ether_type[7:0], packet_byte};
    end else if (byte_position inside {[POS_SRC_FIRST:POS_SRC_LAST]}) begin
      source_address_next = {source_address[23:0], packet_byte};
    end else if (byte_position inside {[POS_DST_FIRST:POS_DST_LAST]}) begin
      dest_address_next = {dest_address[23:0], packet_byte};
    end
    if (byte_position < IPV4_MIN_FRAME) begin
      byte_position_next = byte_position + 6'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  // Request built from this item: a table write or a classified frame.
  always_comb begin
    push_req.is_write    = (op == OP_WRITE);
    push_req.slot        = entry_slot;
    push_req.entry_valid = entry_valid;
    if (op == OP_WRITE) begin
      push_req.pair = {entry_source, entry_dest};
    end else begin
      push_req.pair = {source_address_next, dest_address_next};
    end
    if (byte_position_next < ETH_HEADER_LEN) begin
      push_req.reason = REASON_TOO_SHORT;
    end else if (ether_type_next != ETHERTYPE_IPV4) begin
      push_req.reason = REASON_NOT_IPV4;
    end else if (byte_position_next < IPV4_MIN_FRAME) begin
      push_req.reason = REASON_TOO_SHORT;
    end else begin
      push_req.reason = REASON_NOT_IN_TABLE;
    end
  end

  // Frame state: advances on each packet byte, clears after the last one.
  always_ff @(posedge clk) begin
    if (rst || frame_end) begin
      byte_position  <= '0;
      ether_type     <= '0;
      source_address <= '0;
      dest_address   <= '0;
    end else if (accept && op == OP_BYTE) begin
      byte_position  <= byte_position_next;
      ether_type     <= ether_type_next;
      source_address <= source_address_next;
      dest_address   <= dest_address_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ipaf_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none

module ipaf_queue
  import ipaf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_req,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output req_t      head_req
);

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_req   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  // Pointers and fill count; pointers wrap at the power-of-two depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ipaf_back.sv
// Back end: allowlist table, pair lookup, statistics and the result register.
`default_nettype none

module ipaf_back
  import ipaf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire req_t   head_req,
  output logic        pop,
  output logic        result_valid,
  input  wire logic   result_ready,
  output logic        verdict,
  output logic [1:0]  reason,
  output logic [63:0] total_count,
  output logic [63:0] allowed_count,
  output logic [63:0] dropped_count,
  output logic [63:0] invalid_count
);

  logic [63:0]            table_pair  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] table_valid;
  logic [63:0]            stat [STAT_COUNT];

  logic                     s1_valid;
  logic [1:0]               s1_reason;
  logic [TABLE_ENTRIES-1:0] s1_hit;

  logic             s1_adv;
  logic             s1_load_ok;
  logic             pop_write;
  logic             pop_frame;
  logic             slot_in_range;
  logic [IDX_W-1:0] slot_idx;
  logic [1:0]       final_reason;

  // Pipeline flow control: writes retire at the pop, frames take a stage.
  assign s1_adv        = s1_valid && (!result_valid || result_ready);
  assign s1_load_ok    = !s1_valid || s1_adv;
  assign pop           = head_valid && (head_req.is_write || s1_load_ok);
  assign pop_write     = pop && head_req.is_write;
  assign pop_frame     = pop && !head_req.is_write;
  assign slot_in_range = (32'(head_req.slot) < TABLE_ENTRIES);
  assign slot_idx      = IDX_W'(head_req.slot);

  // Table contents; the pair is stored even when the slot is disabled.
  always_ff @(posedge clk) begin
    if (pop_write && slot_in_range) begin
      table_pair[slot_idx] <= head_req.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_valid <= '0;
    end else if (pop_write && slot_in_range) begin
      table_valid[slot_idx] <= head_req.entry_valid;
    end
  end

  // Lookup stage: one comparator per slot, hit vector registered.
  always_ff @(posedge clk) begin
    if (pop_frame) begin
      s1_reason <= head_req.reason;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        s1_hit[i] <= table_valid[i] && (table_pair[i] == head_req.pair);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop_frame) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Final reason once the hit vector is reduced.
  always_comb begin
    if (s1_reason == REASON_NOT_IN_TABLE && (|s1_hit)) begin
      final_reason = REASON_ALLOWED;
    end else begin
      final_reason = s1_reason;
    end
  end

  // Result register and counters; the counters move only with a new result.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      for (int j = 0; j < STAT_COUNT; j++) begin
        stat[j] <= '0;
      end
    end else if (s1_adv) begin
      result_valid     <= 1'b1;
      stat[CNT_FRAMES] <= stat[CNT_FRAMES] + 64'd1;
      case (final_reason)
        REASON_ALLOWED:      stat[CNT_PASSED]   <= stat[CNT_PASSED] + 64'd1;
        REASON_NOT_IN_TABLE: stat[CNT_NO_MATCH] <= stat[CNT_NO_MATCH] + 64'd1;
        REASON_TOO_SHORT:    stat[CNT_SHORT]    <= stat[CNT_SHORT] + 64'd1;
        default: ;
      endcase
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      reason <= final_reason;
      if (final_reason == REASON_NOT_IPV4 || final_reason == REASON_ALLOWED) begin
        verdict <= VERDICT_PASS;
      end else begin
        verdict <= VERDICT_DROP;
      end
    end
  end

  assign total_count   = stat[CNT_FRAMES];
  assign allowed_count = stat[CNT_PASSED];
  assign dropped_count = stat[CNT_NO_MATCH];
  assign invalid_count = stat[CNT_SHORT];

endmodule

`default_nettype wire

FILE: hdl/ipv4_pair_allowlist_filter.sv
// Top level of the IPv4 source and destination address pair allowlist filter.
//
// The item channel (item_valid / item_ready) carries one request per cycle:
// either one frame byte with its last-byte mark, or a write of one allowlist
// slot. Only the last byte of a frame produces a result on the result channel
// (result_valid / result_ready): the verdict, its reason and the four
// statistics counters after this frame's update.
// A request is accepted every cycle while the four-entry request queue has
// room. Accepting the last byte of a frame writes its queue entry, the lookup
// stage registers the 64-way table compare when it pops, and the result
// register then takes the reduced hits together with the counter update.
// Table writes take effect in request order, so a write after a frame's last
// byte never changes that frame's verdict.
// When the receiver holds result_ready low, the result register holds, the
// lookup stage and then the queue fill, and item_ready drops once the queue
// is full. Synchronous reset empties the queue, clears the frame state, all
// table valid bits and all counters; slot contents stay as they were.
`default_nettype none

module ipv4_pair_allowlist_filter
  import ipaf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic        op,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        last_byte,
  input  wire logic [5:0]  entry_slot,
  input  wire logic [31:0] entry_source,
  input  wire logic [31:0] entry_dest,
  input  wire logic        entry_valid,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             verdict,
  output logic [1:0]       reason,
  output logic [63:0]      total_count,
  output logic [63:0]      allowed_count,
  output logic [63:0]      dropped_count,
  output logic [63:0]      invalid_count
);

  logic q_push;
  req_t q_push_req;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  req_t q_head_req;

  ipaf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .packet_byte  (packet_byte),
    .last_byte    (last_byte),
    .entry_slot   (entry_slot),
    .entry_source (entry_source),
    .entry_dest   (entry_dest),
    .entry_valid  (entry_valid),
    .queue_full   (q_full),
    .push         (q_push),
    .push_req     (q_push_req)
  );

  ipaf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_req   (q_push_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_req   (q_head_req)
  );

  ipaf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head_req      (q_head_req),
    .pop           (q_pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .verdict       (verdict),
    .reason        (reason),
    .total_count   (total_count),
    .allowed_count (allowed_count),
    .dropped_count (dropped_count),
    .invalid_count (invalid_count)
  );

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

  // The queue is only popped when it holds a request.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("request popped from an empty queue");

  // The frame counter moves only when a fresh result is loaded.
  a_count_with_result: assert property (@(posedge clk) disable iff (rst)
    !$stable(total_count) |-> result_valid && (!$past(result_valid) || $past(result_ready)))
    else $error("frame counter changed without a new result");

  // A pass verdict goes only with a non-IPv4 or allowed reason.
  a_verdict_reason: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((verdict == VERDICT_PASS) ==
      (reason == REASON_NOT_IPV4 || reason == REASON_ALLOWED)))
    else $error("verdict does not match reason");

endmodule

`default_nettype wire
